// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every rising edge out of reset.
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising edge out of reset.
`define SPQ_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQ_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned PriBits  = 16;
  localparam int unsigned TagBits  = 16;
  localparam int unsigned CountOut = 5;
  localparam int unsigned CapBits  = 5;
  localparam logic [CapBits-1:0] CapReset = 5'd16;

  // request mode codes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } spq_err_e;

  typedef struct packed {
    logic               mode;
    logic [PriBits-1:0] priority_req;
    logic [TagBits-1:0] tag;
  } spq_req_t;

  typedef struct packed {
    logic                out_valid;
    logic [PriBits-1:0]  out_priority;
    logic [TagBits-1:0]  out_tag;
    logic [CountOut-1:0] count;
    logic                empty_res;
    logic                full_res;
    spq_err_e            error;
  } spq_res_t;

  // one stored entry
  typedef struct packed {
    logic [PriBits-1:0] pri;
    logic [TagBits-1:0] tag;
  } spq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t ins;
  } spq_cmd_t;

endpackage

// File: rtl/spq_cell.sv
// One slot of the sorted chain. Cell 0 is the head.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  logic                occupied_i,
  input  logic                prev_gt_i,
  input  spq_pkg::spq_entry_t prev_entry_i,
  input  spq_pkg::spq_entry_t next_entry_i,
  output logic                gt_o,
  output spq_pkg::spq_entry_t entry_o
);

  spq_pkg::spq_entry_t entry_q, entry_d;

  // new entry goes at or ahead of this slot: slot empty or strictly lower
  assign gt_o = !occupied_i || (cmd_i.ins.pri > entry_q.pri);

  // insert / shift down on enqueue, shift up on dequeue
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq && gt_o) begin
      entry_d = prev_gt_i ? prev_entry_i : cmd_i.ins;
    end else if (cmd_i.deq) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/sorted_priority_queue.sv
// Channel  Direction  Handshake                 Payload
// req      in         req_valid_i / req_stall_o  req_i  (spq_req_t)
// res      out        res_valid_o / res_stall_i  res_o  (spq_res_t)
// cfg      in         cfg_valid_i / cfg_ready_o  cfg_data_i (capacity)
//
// One item per cycle while req_stall_o is low: the cell chain compares and shifts
// combinationally, and each result appears in the output register in the cycle after its item.
// Reset empties the queue at once (count zero) and sets capacity to 16.
// req_stall_o is high only while a result is held and res_stall_i is high.
`include "assert_macros.svh"

module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_stall_o,
  input  spq_pkg::spq_req_t            req_i,
  output logic                         res_valid_o,
  input  logic                         res_stall_i,
  output spq_pkg::spq_res_t            res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [spq_pkg::CapBits-1:0]  cfg_data_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [spq_pkg::CapBits-1:0] cap_q;
  logic [CW-1:0]               count_q, count_d, cap_eff;
  logic                        res_valid_q;
  spq_pkg::spq_res_t           res_q, res_d;
  spq_pkg::spq_cmd_t           cmd;
  logic                        accept, can_enq, can_deq;
  logic [31:0]                 count_w;

  logic                        gt     [DEPTH];
  spq_pkg::spq_entry_t         entry  [DEPTH];

  // configuration port is always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= spq_pkg::CapReset;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // clamp capacity into 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  // handshake
  assign req_stall_o = res_valid_q && res_stall_i;
  assign accept      = req_valid_i && !req_stall_o;

  assign can_enq = count_q < cap_eff;
  assign can_deq = count_q != '0;

  assign cmd.enq     = accept && (req_i.mode == spq_pkg::MODE_ENQ) && can_enq;
  assign cmd.deq     = accept && (req_i.mode == spq_pkg::MODE_DEQ) && can_deq;
  assign cmd.ins.pri = req_i.priority_req;
  assign cmd.ins.tag = req_i.tag;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                occ;
    logic                pgt;
    spq_pkg::spq_entry_t pent, nent;

    assign occ = 32'(count_q) > i;
    if (i == 0) begin : g_head
      assign pgt  = 1'b0;
      assign pent = cmd.ins;
    end else begin : g_body
      assign pgt  = gt[i-1];
      assign pent = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nent = entry[i];
    end else begin : g_mid
      assign nent = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (occ),
      .prev_gt_i    (pgt),
      .prev_entry_i (pent),
      .next_entry_i (nent),
      .gt_o         (gt[i]),
      .entry_o      (entry[i])
    );
  end

  // count and result
  always_comb begin
    count_d = count_q;
    if (cmd.enq) begin
      count_d = count_q + CW'(1);
    end else if (cmd.deq) begin
      count_d = count_q - CW'(1);
    end
    count_w = 32'(count_d);

    res_d.out_valid    = cmd.deq;
    res_d.out_priority = cmd.deq ? entry[0].pri : '0;
    res_d.out_tag      = cmd.deq ? entry[0].tag : '0;
    res_d.count        = count_w[spq_pkg::CountOut-1:0];
    res_d.empty_res    = count_d == '0;
    res_d.full_res     = count_d >= cap_eff;
    res_d.error        = spq_pkg::ERR_OK;
    if (req_i.mode == spq_pkg::MODE_ENQ && !can_enq) begin
      res_d.error = spq_pkg::ERR_FULL;
    end else if (req_i.mode == spq_pkg::MODE_DEQ && !can_deq) begin
      res_d.error = spq_pkg::ERR_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `SPQ_ASSERT(a_deq_count, clk_i, rst_ni, cmd.deq |=> count_q == $past(count_q) - CW'(1), "dequeue did not lower count")
  `SPQ_ASSERT(a_head_max, clk_i, rst_ni, cmd.enq |=> entry[0].pri >= $past(req_i.priority_req), "head below inserted priority")
  `SPQ_ASSERT(a_sorted, clk_i, rst_ni, count_q >= CW'(2) |-> entry[0].pri >= entry[1].pri, "head pair out of order")
  `SPQ_NEVER(a_full_err, clk_i, rst_ni, res_valid_q && res_q.error == spq_pkg::ERR_FULL && !res_q.full_res, "full error without full flag")
  `SPQ_NEVER(a_over_depth, clk_i, rst_ni, 32'(count_q) > DEPTH, "count beyond depth")

endmodule

// File: tb/spq_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and capacity channels of the sorted priority
// queue, keeps its own copy of the queue contents and compares every result.
module spq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic                        req_stall_i,
  input  spq_pkg::spq_req_t           req_i,
  input  logic                        res_valid_i,
  input  logic                        res_stall_i,
  input  spq_pkg::spq_res_t           res_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [spq_pkg::CapBits-1:0] cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam int unsigned CountW = spq_pkg::CountOut;

  // held entries, highest priority at the front
  spq_pkg::spq_entry_t         held_entries[$];
  spq_pkg::spq_res_t           due_results[$];
  logic [spq_pkg::CapBits-1:0] capacity_q;
  int                          fails = 0;

  // capacity as the queue applies it: zero acts as one, clipped to DEPTH
  function automatic int unsigned capacity_limit();
    if (capacity_q == '0) return 1;
    if (capacity_q > DEPTH) return DEPTH;
    return capacity_q;
  endfunction

  // apply one command to the held entries and build the result it yields
  function automatic spq_pkg::spq_res_t apply_queue_op(spq_pkg::spq_req_t cmd);
    spq_pkg::spq_res_t   res;
    spq_pkg::spq_entry_t ent;
    int                  pos;
    int unsigned         limit;
    limit     = capacity_limit();
    res       = '0;
    res.error = spq_pkg::ERR_OK;
    if (cmd.mode == spq_pkg::MODE_ENQ) begin
      if (held_entries.size() >= limit) begin
        res.error = spq_pkg::ERR_FULL;
      end else begin
        // new entry goes ahead of every strictly lower priority only
        pos = held_entries.size();
        for (int i = held_entries.size() - 1; i >= 0; i--) begin
          if (held_entries[i].pri < cmd.priority_req) pos = i;
          else break;
        end
        ent.pri = cmd.priority_req;
        ent.tag = cmd.tag;
        held_entries.insert(pos, ent);
      end
    end else if (held_entries.size() == 0) begin
      res.error = spq_pkg::ERR_EMPTY;
    end else begin
      ent              = held_entries.pop_front();
      res.out_valid    = 1'b1;
      res.out_priority = ent.pri;
      res.out_tag      = ent.tag;
    end
    res.count     = CountW'(held_entries.size());
    res.empty_res = (held_entries.size() == 0);
    res.full_res  = (held_entries.size() >= limit);
    return res;
  endfunction

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit result_ok(spq_pkg::spq_res_t want, spq_pkg::spq_res_t got);
    bit ok;
    ok = 1'b1;
    ok &= field_ok("out_valid", 32'(want.out_valid), 32'(got.out_valid));
    ok &= field_ok("out_priority", 32'(want.out_priority), 32'(got.out_priority));
    ok &= field_ok("out_tag", 32'(want.out_tag), 32'(got.out_tag));
    ok &= field_ok("count", 32'(want.count), 32'(got.count));
    ok &= field_ok("empty_res", 32'(want.empty_res), 32'(got.empty_res));
    ok &= field_ok("full_res", 32'(want.full_res), 32'(got.full_res));
    ok &= field_ok("error", 32'(want.error), 32'(got.error));
    return ok;
  endfunction

  // channel monitor: capacity write, then result check, then new request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_entries.delete();
      due_results.delete();
      capacity_q   = spq_pkg::CapReset;
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity_q = cfg_data_i;
      if (res_valid_i && !res_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result item arrived with no command outstanding");
          fails++;
        end else if (!result_ok(due_results.pop_front(), res_i)) begin
          fails++;
        end
      end
      if (req_valid_i && !req_stall_i) due_results.push_back(apply_queue_op(req_i));
      pending_o    <= due_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned QueueDepth  = 16;
  localparam int          RandomItems = 1430;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  spq_pkg::spq_req_t           req       = '0;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  spq_pkg::spq_res_t           res;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [spq_pkg::CapBits-1:0] cfg_data  = spq_pkg::CapReset;
  int                          fail_count;
  int                          pending;

  int                          items_sent = 0;
  int                          burst_left = 0;
  logic [5:0]                  stall_cycle = '0;
  stall_style_e                stall_style = STALL_NONE;

  sorted_priority_queue #(
    .DEPTH(QueueDepth)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_valid),
    .req_stall_o(req_stall),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_stall_i(res_stall),
    .res_o      (res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  spq_checker #(
    .DEPTH(QueueDepth)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_stall_i (req_stall),
    .req_i       (req),
    .res_valid_i (res_valid),
    .res_stall_i (res_stall),
    .res_i       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result stall: a new style is drawn each time the six-bit stall_cycle counter wraps
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 6'd1;
    if (stall_cycle == '0) stall_style <= stall_style_e'($urandom_range(3));
    case (stall_style)
      STALL_NONE:  res_stall <= 1'b0;
      STALL_LIGHT: res_stall <= ($urandom_range(3) == 0);
      STALL_HEAVY: res_stall <= ($urandom_range(3) != 0);
      default:     res_stall <= stall_cycle[2];
    endcase
  end

  function automatic spq_pkg::spq_req_t enq_cmd(logic [spq_pkg::PriBits-1:0] pri,
                                                logic [spq_pkg::TagBits-1:0] tag);
    spq_pkg::spq_req_t r;
    r.mode         = spq_pkg::MODE_ENQ;
    r.priority_req = pri;
    r.tag          = tag;
    return r;
  endfunction

  // dequeue ignores the entry fields; fill them with noise anyway
  function automatic spq_pkg::spq_req_t deq_cmd();
    spq_pkg::spq_req_t r;
    r.mode         = spq_pkg::MODE_DEQ;
    r.priority_req = 16'($urandom_range(16'hFFFF));
    r.tag          = 16'($urandom_range(16'hFFFF));
    return r;
  endfunction

  // send one command; bursts of random length separated by random gaps
  task automatic send_cmd(spq_pkg::spq_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(logic [spq_pkg::CapBits-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random phase: one capacity, one mix of commands, one priority spread
  task automatic random_phase();
    int                          n_items;
    int                          enq_pct;
    int                          pri_style;
    logic [spq_pkg::CapBits-1:0] cap;
    logic [spq_pkg::PriBits-1:0] pri;
    case ($urandom_range(7))
      0:       cap = 5'd0;
      1:       cap = 5'd1;
      2:       cap = 5'd2;
      3:       cap = 5'd16;
      4:       cap = 5'd17;
      5:       cap = 5'd31;
      default: cap = 5'($urandom_range(1, 16));
    endcase
    write_capacity(cap);
    n_items   = $urandom_range(30, 120);
    enq_pct   = 30 + 20 * $urandom_range(2);
    pri_style = $urandom_range(2);
    repeat (n_items) begin
      case (pri_style)
        0:       pri = 16'($urandom_range(3));
        1:       pri = 16'($urandom_range(16'hFFFF));
        default: pri = ($urandom_range(1) != 0) ? 16'(32'hFFFF - $urandom_range(1))
                                                : 16'($urandom_range(1));
      endcase
      if ($urandom_range(99) < enq_pct) begin
        send_cmd(enq_cmd(pri, 16'($urandom_range(16'hFFFF))));
      end else begin
        send_cmd(deq_cmd());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: empty dequeue, extremes, tie at the top priority
    send_cmd(deq_cmd());
    send_cmd(enq_cmd(16'h0000, 16'h0000));
    send_cmd(enq_cmd(16'hFFFF, 16'hFFFF));
    send_cmd(enq_cmd(16'hFFFF, 16'h0001));
    send_cmd(enq_cmd(16'h1234, 16'hABCD));
    repeat (4) send_cmd(deq_cmd());
    send_cmd(deq_cmd());

    // capacity zero behaves as one: second enqueue refused
    write_capacity(5'd0);
    send_cmd(enq_cmd(16'h0007, 16'h0007));
    send_cmd(enq_cmd(16'h0008, 16'h0008));
    send_cmd(deq_cmd());

    // capacity above depth clips to depth
    write_capacity(5'd31);
    send_cmd(enq_cmd(16'h0005, 16'h1111));
    send_cmd(enq_cmd(16'h0005, 16'h2222));
    send_cmd(enq_cmd(16'h0009, 16'h3333));

    // capacity lowered below the held count: entries kept, enqueue refused
    write_capacity(5'd2);
    send_cmd(enq_cmd(16'h7FFF, 16'h4444));
    repeat (2) send_cmd(deq_cmd());
    send_cmd(enq_cmd(16'h8000, 16'h5555));
    repeat (2) send_cmd(deq_cmd());

    while (items_sent < RandomItems + 22) random_phase();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
